// File: rtl/fas_pkg.sv
// Shared types and constants for the filtered altitude slope block.
`default_nettype none
package fas_pkg;

    localparam int ALT_W      = 25;
    localparam int DIST_W     = 20;
    localparam int ALPHA_W    = 17;
    localparam int LIMIT_W    = 15;
    localparam int SLOPE_W    = 16;
    localparam int QUO_W      = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int ALPHA_FRAC = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] SLOPE_SCALE = 17'd10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd1311;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd3000;

    // register index taken from paddr[2]
    localparam logic REG_SMOOTHING = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;

    typedef struct packed {
        logic signed [ALT_W-1:0] altitude_mm;
        logic [DIST_W-1:0]       distance_step_mm;
        logic                    first_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope_centi_percent;
        logic                      slope_held;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_SEED,
        KIND_ZERO_DIST,
        KIND_SLOPE
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [ALT_W-1:0] altitude_mm;
        logic [DIST_W-1:0]       distance;
    } job_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic             overflow;
        logic             rem_nonzero;
        logic             round_up;
        logic [QUO_W-1:0] quotient;
    } div_status_t;

endpackage
`default_nettype wire

// File: rtl/fas_regs.sv
// APB configuration registers: smoothing factor and slope limit.
`default_nettype none
module fas_regs
    import fas_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [ALPHA_W-1:0] alpha_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SMOOTHING: alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_LIMIT:     limit_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SMOOTHING: prdata = DATA_W'(alpha_reg);
            REG_LIMIT:     prdata = DATA_W'(limit_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.alpha = alpha_reg;
    assign cfg.limit = limit_reg;

endmodule
`default_nettype wire

// File: rtl/fas_front.sv
// Input side: takes samples, classifies them and queues them for the back end.
`default_nettype none
module fas_front
    import fas_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          job_valid,
    output job_t          job,
    input  wire logic     job_pop
);

    localparam int DEPTH = 2;

    job_t       fifo_mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    job_t       job_in;
    logic       push;
    logic       pop;

    always_comb begin
        job_in.altitude_mm = s_data.altitude_mm;
        job_in.distance    = s_data.distance_step_mm;
        if (s_data.first_sample) begin
            job_in.kind = KIND_SEED;
        end else if (s_data.distance_step_mm == '0) begin
            job_in.kind = KIND_ZERO_DIST;
        end else begin
            job_in.kind = KIND_SLOPE;
        end
    end

    assign s_ready   = (count_reg != 2'(DEPTH));
    assign job_valid = (count_reg != 2'd0);
    assign job       = fifo_mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = job_pop && job_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/fas_smul.sv
// Shift-add multiplier: signed multiplicand times 17-bit unsigned, one bit per cycle.
`default_nettype none
module fas_smul
    import fas_pkg::*;
#(
    parameter int A_W = 42
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic signed [A_W-1:0]       a,
    input  wire logic [ALPHA_W-1:0]          b,
    output logic                             done,
    output logic signed [A_W+ALPHA_W-1:0]    product
);

    localparam int P_W   = A_W + ALPHA_W;
    localparam int CNT_W = $clog2(ALPHA_W);

    typedef enum logic {
        M_IDLE,
        M_RUN
    } mstate_t;

    mstate_t                state_reg;
    logic signed [P_W-1:0]  acc_reg;
    logic signed [P_W-1:0]  mcand_reg;
    logic [ALPHA_W-1:0]     mplier_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        acc_reg    <= '0;
                        mcand_reg  <= P_W'(a);
                        mplier_reg <= b;
                        cnt_reg    <= '0;
                        state_reg  <= M_RUN;
                    end
                end
                M_RUN: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ALPHA_W - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// File: rtl/fas_sdiv.sv
// Restoring divider: 16 quotient bits with overflow, remainder and rounding flags.
`default_nettype none
module fas_sdiv
    import fas_pkg::*;
#(
    parameter int N_W = 59,
    parameter int D_W = 36
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output div_status_t         status
);

    localparam int R_W   = D_W + QUO_W;
    localparam int H_W   = N_W - QUO_W;
    localparam int C_W   = (H_W > D_W) ? H_W : D_W;
    localparam int CNT_W = $clog2(QUO_W);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIN
    } dstate_t;

    dstate_t          state_reg;
    logic [R_W-1:0]   rem_reg;
    logic [R_W-1:0]   dsh_reg;
    logic [D_W-1:0]   den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    div_status_t      status_reg;
    logic [C_W-1:0]   hi_ext;
    logic [C_W-1:0]   den_ext;
    logic             ovf;
    logic             ge;

    // quotient needs more than 16 bits exactly when num >= den * 2^16
    assign hi_ext  = C_W'(num[N_W-1:QUO_W]);
    assign den_ext = C_W'(den);
    assign ovf     = (hi_ext >= den_ext);
    assign ge      = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= DV_IDLE;
            status_reg.done <= 1'b0;
            cnt_reg         <= '0;
        end else begin
            status_reg.done <= 1'b0;
            case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        den_reg <= den;
                        if (ovf) begin
                            status_reg.done     <= 1'b1;
                            status_reg.overflow <= 1'b1;
                        end else begin
                            rem_reg   <= R_W'(num);
                            dsh_reg   <= R_W'({den, {(QUO_W-1){1'b0}}});
                            cnt_reg   <= CNT_W'(QUO_W - 1);
                            state_reg <= DV_RUN;
                        end
                    end
                end
                DV_RUN: begin
                    if (ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    quo_reg <= {quo_reg[QUO_W-2:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    status_reg.done        <= 1'b1;
                    status_reg.overflow    <= 1'b0;
                    status_reg.quotient    <= quo_reg;
                    status_reg.rem_nonzero <= (rem_reg != '0);
                    status_reg.round_up    <= ({rem_reg, 1'b0} >= (R_W+1)'(den_reg));
                    state_reg              <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign status = status_reg;

endmodule
`default_nettype wire

// File: rtl/fas_back.sv
// Back end: filter update, slope scaling and division, held-slope logic, result register.
`default_nettype none
module fas_back
    import fas_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire logic      job_valid,
    input  wire job_t      job,
    output logic           job_pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int FILT_W = ALT_W + FRACTION_BITS;
    localparam int DIFF_W = FILT_W + 1;
    localparam int PROD_W = DIFF_W + ALPHA_W;
    localparam int DEN_W  = DIST_W + FRACTION_BITS;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FILT_START,
        B_FILT_WAIT,
        B_SCALE_START,
        B_SCALE_WAIT,
        B_DIV_START,
        B_DIV_WAIT,
        B_OUT
    } bstate_t;

    bstate_t                   state_reg;
    job_t                      job_reg;
    logic signed [FILT_W-1:0]  filt_reg;
    logic signed [SLOPE_W-1:0] prev_slope_reg;
    logic signed [DIFF_W-1:0]  mag_reg;
    logic                      neg_reg;
    logic [PROD_W-1:0]         num_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic                      held_reg;
    logic                      m_valid_reg;
    out_item_t                 m_data_reg;

    logic signed [FILT_W-1:0]  target;
    logic signed [FILT_W-1:0]  seed_target;
    logic signed [DIFF_W-1:0]  diff;
    logic [ALPHA_W-1:0]        alpha_sat;
    logic                      mul_start;
    logic signed [DIFF_W-1:0]  mul_a;
    logic [ALPHA_W-1:0]        mul_b;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [DIFF_W-1:0]  step;
    logic signed [DIFF_W-1:0]  step_mag;
    logic [DEN_W-1:0]          den;
    div_status_t               div_st;
    logic [QUO_W-1:0]          limit_ext;
    logic                      exceeds;
    logic [QUO_W-1:0]          q_round;

    assign target      = {job_reg.altitude_mm, {FRACTION_BITS{1'b0}}};
    assign seed_target = {job.altitude_mm, {FRACTION_BITS{1'b0}}};
    assign diff        = DIFF_W'(target) - DIFF_W'(filt_reg);
    assign alpha_sat   = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

    // one multiplier serves the filter step and the x10000 scaling
    assign mul_start = (state_reg == B_FILT_START) || (state_reg == B_SCALE_START);
    assign mul_a     = (state_reg == B_FILT_START) ? diff : mag_reg;
    assign mul_b     = (state_reg == B_FILT_START) ? alpha_sat : SLOPE_SCALE;

    fas_smul #(
        .A_W (DIFF_W)
    ) u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // round to nearest, ties toward plus infinity
    assign rnd      = mul_prod + PROD_W'(1 << (ALPHA_FRAC - 1));
    assign step     = DIFF_W'(rnd >>> ALPHA_FRAC);
    assign step_mag = step[DIFF_W-1] ? -step : step;

    assign den = {job_reg.distance, {FRACTION_BITS{1'b0}}};

    fas_sdiv #(
        .N_W (PROD_W),
        .D_W (DEN_W)
    ) u_sdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == B_DIV_START),
        .num     (num_reg),
        .den     (den),
        .status  (div_st)
    );

    // |slope| > limit exactly: quotient above limit, or equal with a remainder
    assign limit_ext = QUO_W'(cfg.limit);
    assign exceeds   = div_st.overflow || (div_st.quotient > limit_ext)
                       || ((div_st.quotient == limit_ext) && div_st.rem_nonzero);
    assign q_round   = div_st.quotient + QUO_W'(div_st.round_up);

    assign job_pop = (state_reg == B_IDLE) && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            filt_reg       <= '0;
            prev_slope_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // in B_OUT a transfer with m_ready high always reloads the register
            if (m_ready && (state_reg != B_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        if (job.kind == KIND_SEED) begin
                            filt_reg       <= seed_target;
                            prev_slope_reg <= '0;
                        end else begin
                            job_reg   <= job;
                            state_reg <= B_FILT_START;
                        end
                    end
                end
                B_FILT_START: state_reg <= B_FILT_WAIT;
                B_FILT_WAIT: begin
                    if (mul_done) begin
                        filt_reg <= filt_reg + FILT_W'(step);
                        mag_reg  <= step_mag;
                        neg_reg  <= step[DIFF_W-1];
                        if (job_reg.kind == KIND_SLOPE) begin
                            state_reg <= B_SCALE_START;
                        end else begin
                            slope_reg <= prev_slope_reg;
                            held_reg  <= 1'b1;
                            state_reg <= B_OUT;
                        end
                    end
                end
                B_SCALE_START: state_reg <= B_SCALE_WAIT;
                B_SCALE_WAIT: begin
                    if (mul_done) begin
                        num_reg   <= PROD_W'(mul_prod);
                        state_reg <= B_DIV_START;
                    end
                end
                B_DIV_START: state_reg <= B_DIV_WAIT;
                B_DIV_WAIT: begin
                    if (div_st.done) begin
                        if (exceeds) begin
                            slope_reg <= prev_slope_reg;
                            held_reg  <= 1'b1;
                        end else begin
                            slope_reg <= neg_reg ? -SLOPE_W'(q_round) : SLOPE_W'(q_round);
                            held_reg  <= 1'b0;
                        end
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                    <= 1'b1;
                        m_data_reg.slope_centi_percent <= slope_reg;
                        m_data_reg.slope_held          <= held_reg;
                        prev_slope_reg                 <= slope_reg;
                        state_reg                      <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// File: rtl/filtered_altitude_slope.sv
// Top level: filtered altitude slope with APB configuration.
//
//   channel   ports                        payload
//   input     s_valid / s_ready / s_data   in_item_t (altitude, distance, first flag)
//   result    m_valid / m_ready / m_data   out_item_t (slope, held flag)
//   config    APB psel..pready             smoothing_factor @0x0, slope_limit @0x4
//
// A slope sample passes from the queue through two passes of the shift-add
// multiplier (filter step, then x10000 scaling) and the restoring divider before
// it reaches the output register; a seed sample only reloads the filter.
// A zero-distance sample skips the scaling and division; a quotient too large
// for 16 bits skips the divider iterations.
// Synchronous active-low reset clears the filter and the previous slope.
// A two-entry queue buffers samples while the back end works; a finished
// result waits in the output register until its transfer.
`default_nettype none
module filtered_altitude_slope
    import fas_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_item_t              m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t cfg;
    logic job_valid;
    job_t job;
    logic job_pop;

    fas_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fas_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    fas_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// File: tb/tb_filtered_altitude_slope.sv
// Self-checking testbench for filtered_altitude_slope: directed table, then random phases.
`timescale 1ns / 1ps
module tb_filtered_altitude_slope;
    import fas_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int SETTLE_CYCLES = 200;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 63;
    localparam int DIRECTED_ROWS = 23;

    localparam logic signed [ALT_W-1:0] ALT_MAX = 25'sh0FFFFFF;
    localparam logic signed [ALT_W-1:0] ALT_MIN = 25'sh1000000;
    localparam logic [DIST_W-1:0]       DIST_MAX = 20'hFFFFF;

    typedef struct packed {
        logic signed [ALT_W-1:0]   alt;
        logic [DIST_W-1:0]         distance;
        logic                      first;
        logic                      typed;
        logic signed [SLOPE_W-1:0] slope;
        logic                      held;
    } directed_row_t;

    // typed = 1: the slope/held columns are the expected result
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{25'sd0,        20'd1000,    1'b0, 1'b1, 16'sd0, 1'b0}, // no seed yet
        '{25'sd0,        20'd0,       1'b0, 1'b1, 16'sd0, 1'b1}, // zero distance
        '{ALT_MAX,       20'd1000,    1'b1, 1'b0, 16'sd0, 1'b0},
        '{ALT_MAX,       20'd1000,    1'b0, 1'b1, 16'sd0, 1'b0}, // filter on the sample
        '{ALT_MAX,       DIST_MAX,    1'b0, 1'b1, 16'sd0, 1'b0},
        '{ALT_MIN,       DIST_MAX,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{ALT_MIN,       20'd1,       1'b0, 1'b0, 16'sd0, 1'b0},
        '{ALT_MIN,       20'd1,       1'b1, 1'b0, 16'sd0, 1'b0},
        '{ALT_MIN,       20'd1,       1'b0, 1'b1, 16'sd0, 1'b0},
        '{25'sd0,        20'd5000,    1'b1, 1'b0, 16'sd0, 1'b0},
        '{25'sd100,      20'd10000,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sd200,      20'd10000,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sd300,      20'd5000,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sd250,      20'd5000,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sd250,      20'd0,       1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sd250,      20'd5000,    1'b1, 1'b0, 16'sd0, 1'b0},
        '{25'sd250,      20'd0,       1'b0, 1'b1, 16'sd0, 1'b1}, // seed cleared old slope
        '{25'sd100000,   20'd1000,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{-25'sd1000000, 20'd2000,    1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sh0AAAAAA,  20'h55555,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sh1555555,  20'hAAAAA,   1'b0, 1'b0, 16'sd0, 1'b0},
        '{25'sd10000000, 20'd3,       1'b1, 1'b0, 16'sd0, 1'b0},
        '{25'sd10000000, 20'd1000000, 1'b0, 1'b1, 16'sd0, 1'b0}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // shadow of the block: filter in Q16 mm, last slope, register copies
    longint                    filt_q16;
    logic signed [SLOPE_W-1:0] last_slope;
    logic [ALPHA_W-1:0]        alpha_cfg;
    logic [LIMIT_W-1:0]        limit_cfg;

    out_item_t   pending_slopes[$];
    out_item_t   oldest_slope;
    int          fail_count = 0;
    bit          quiet = 1'b0;
    int unsigned cycle_count = 0;

    filtered_altitude_slope #(.FRACTION_BITS(FRAC_BITS)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Advance the filter by one sample; returns 1 when the sample yields a slope.
    function automatic bit advance_filter(input in_item_t it, output out_item_t slope_out);
        longint                    target, old_q, diff, lo, hi, alpha, delta;
        longint unsigned           mag, num, den, lim, quo;
        logic signed [SLOPE_W-1:0] slope;
        bit                        held;
        slope_out = '0;
        target = longint'($signed(it.altitude_mm)) <<< FRAC_BITS;
        alpha = (alpha_cfg > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_cfg);
        if (it.first_sample) begin
            filt_q16 = target;
            last_slope = '0;
            return 1'b0;
        end
        old_q = filt_q16;
        diff = target - old_q;
        // split so the low part rounds half up without overflow
        lo = diff & ((64'sd1 <<< ALPHA_FRAC) - 1);
        hi = diff >>> ALPHA_FRAC;
        filt_q16 = old_q + hi * alpha
                   + ((lo * alpha + (64'sd1 <<< (ALPHA_FRAC - 1))) >>> ALPHA_FRAC);
        delta = filt_q16 - old_q;
        slope = last_slope;
        held = 1'b1;
        if (it.distance_step_mm != '0) begin
            mag = (delta < 0) ? -delta : delta;
            num = mag * SLOPE_SCALE;
            den = longint'(it.distance_step_mm) << FRAC_BITS;
            lim = 64'(limit_cfg);
            if (num <= lim * den) begin
                quo = (num + den / 2) / den;
                slope = quo[SLOPE_W-1:0];
                if (delta < 0) slope = -slope;
                held = 1'b0;
            end
        end
        last_slope = slope;
        slope_out.slope_centi_percent = slope;
        slope_out.slope_held = held;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return DIST_W'($urandom_range(1, 10));
            2: return DIST_W'($urandom);
            default: return DIST_W'($urandom_range(200, 20000));
        endcase
    endfunction

    task automatic send_sample(input in_item_t it, input bit typed, input out_item_t typed_out);
        int        gap;
        out_item_t want;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (advance_filter(it, want)) pending_slopes.push_back(typed ? typed_out : want);
    endtask

    task automatic apb_access(input logic wr, input logic idx, input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [DATA_W-1:0] expected);
        logic [DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== expected) begin
            $error("%s readback: expected %0d, actual %0d",
                   (idx == REG_SMOOTHING) ? "smoothing_factor" : "slope_limit", expected, rd);
            fail_count++;
        end
    endtask

    task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask, wdata, rd;
        mask = (idx == REG_SMOOTHING) ? {{(DATA_W-ALPHA_W){1'b0}}, {ALPHA_W{1'b1}}}
                                      : {{(DATA_W-LIMIT_W){1'b0}}, {LIMIT_W{1'b1}}};
        // unused upper bits get junk half the time
        wdata = value & mask;
        if ($urandom_range(0, 1) == 1) wdata = wdata | ($urandom & ~mask);
        apb_access(1'b1, idx, wdata, rd);
        if (idx == REG_SMOOTHING) alpha_cfg = wdata[ALPHA_W-1:0];
        else limit_cfg = wdata[LIMIT_W-1:0];
        check_register(idx, wdata & mask);
    endtask

    // Drain: all slopes back, then room for a seed still in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_slopes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly seeded climbs/descents with random grades, some raw noise.
    task automatic run_phase(input int count);
        int          sent, run_len, k;
        longint      alt, change;
        in_item_t    it;
        out_item_t   none;
        sent = 0;
        none = '0;
        while (sent < count) begin
            if ($urandom_range(0, 6) == 0) begin
                it.altitude_mm = ALT_W'($urandom);
                it.distance_step_mm = DIST_W'($urandom);
                it.first_sample = ($urandom_range(0, 3) == 0);
                send_sample(it, 1'b0, none);
                sent++;
            end else begin
                alt = longint'($urandom_range(0, 11000000)) - 1000000;
                it.altitude_mm = alt[ALT_W-1:0];
                it.distance_step_mm = DIST_W'($urandom);
                it.first_sample = 1'b1;
                send_sample(it, 1'b0, none);
                sent++;
                run_len = $urandom_range(3, 20);
                for (k = 0; k < run_len; k++) begin
                    it.distance_step_mm = pick_distance();
                    it.first_sample = 1'b0;
                    change = longint'($urandom_range(0, it.distance_step_mm / 8));
                    if ($urandom_range(0, 19) == 0) change = longint'($urandom_range(0, 2000000));
                    if ($urandom_range(0, 1) == 1) change = -change;
                    alt = alt + change;
                    if (alt > longint'(ALT_MAX)) alt = longint'(ALT_MAX);
                    if (alt < longint'(ALT_MIN)) alt = longint'(ALT_MIN);
                    it.altitude_mm = alt[ALT_W-1:0];
                    send_sample(it, 1'b0, none);
                    sent++;
                end
            end
        end
    endtask

    // result side: ready in runs, broken by random stalls outside the quiet phases
    initial begin
        int run;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
            if (!quiet) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_slopes.size() == 0) begin
                $error("slope transfer with no sample waiting: slope %0d held %0b",
                       m_data.slope_centi_percent, m_data.slope_held);
                fail_count++;
            end else begin
                oldest_slope = pending_slopes.pop_front();
                if (m_data.slope_centi_percent !== oldest_slope.slope_centi_percent) begin
                    $error("slope_centi_percent: expected %0d, actual %0d",
                           oldest_slope.slope_centi_percent, m_data.slope_centi_percent);
                    fail_count++;
                end
                if (m_data.slope_held !== oldest_slope.slope_held) begin
                    $error("slope_held: expected %0b, actual %0b",
                           oldest_slope.slope_held, m_data.slope_held);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        in_item_t  it;
        out_item_t row_out;
        int        i, p;
        s_valid <= 1'b0;
        s_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        aresetn <= 1'b0;
        filt_q16 = 0;
        last_slope = '0;
        alpha_cfg = ALPHA_RESET;
        limit_cfg = LIMIT_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        check_register(REG_SMOOTHING, DATA_W'(ALPHA_RESET));
        check_register(REG_LIMIT, DATA_W'(LIMIT_RESET));

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            it.altitude_mm = DIRECTED[i].alt;
            it.distance_step_mm = DIRECTED[i].distance;
            it.first_sample = DIRECTED[i].first;
            row_out.slope_centi_percent = DIRECTED[i].slope;
            row_out.slope_held = DIRECTED[i].held;
            send_sample(it, DIRECTED[i].typed, row_out);
        end
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_register(REG_SMOOTHING, DATA_W'(ALPHA_ONE));
                    write_register(REG_LIMIT, 32767);
                end
                1: begin
                    write_register(REG_SMOOTHING, 0);
                    write_register(REG_LIMIT, 0);
                end
                2: begin // alpha above one saturates
                    write_register(REG_SMOOTHING, 131071);
                    write_register(REG_LIMIT, DATA_W'(LIMIT_RESET));
                end
                3: begin
                    write_register(REG_SMOOTHING, 1);
                    write_register(REG_LIMIT, 1);
                end
                4: begin
                    write_register(REG_SMOOTHING, DATA_W'(ALPHA_RESET));
                    write_register(REG_LIMIT, 32767);
                end
                5: begin
                    write_register(REG_SMOOTHING, 65535);
                    write_register(REG_LIMIT, $urandom_range(0, 32767));
                end
                6: begin
                    write_register(REG_SMOOTHING, $urandom);
                    write_register(REG_LIMIT, $urandom_range(0, 32767));
                end
                default: begin
                    write_register(REG_SMOOTHING, $urandom_range(0, 65536));
                    write_register(REG_LIMIT, DATA_W'(LIMIT_RESET));
                end
            endcase
            quiet = (p == 2 || p == 5);
            run_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/fas_pkg.sv
rtl/fas_regs.sv
rtl/fas_front.sv
rtl/fas_smul.sv
rtl/fas_sdiv.sv
rtl/fas_back.sv
rtl/filtered_altitude_slope.sv
tb/tb_filtered_altitude_slope.sv
